>>> rtl/core/aes_bme_pkg.sv
// Shared types, constants and round functions for the AES-128 block mode engine.
// Used by the controller, the datapath and the top level. No dependencies.
package aes_bme_pkg;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_KEY_HIGH = 3'd0;
    localparam logic [2:0] REG_KEY_LOW  = 3'd1;
    localparam logic [2:0] REG_IV_HIGH  = 3'd2;
    localparam logic [2:0] REG_IV_LOW   = 3'd3;
    localparam logic [2:0] REG_MODE     = 3'd4;

    // Mode codes; codes six and seven run as ECB encrypt.
    localparam logic [2:0] MODE_ECB_ENC = 3'd0;
    localparam logic [2:0] MODE_ECB_DEC = 3'd1;
    localparam logic [2:0] MODE_CBC_ENC = 3'd2;
    localparam logic [2:0] MODE_CBC_DEC = 3'd3;
    localparam logic [2:0] MODE_ECB_MAC = 3'd4;
    localparam logic [2:0] MODE_CBC_MAC = 3'd5;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_VALUE = 2'd1;
    localparam logic [1:0] ST_BAD_PAD   = 2'd2;

    localparam logic [3:0] LAST_ROUND = 4'd10;
    localparam logic [4:0] BLOCK_BYTES = 5'd16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_item;
        logic       load_pad;
        logic       step;
        logic       emit;
        logic       kx_load;
        logic       kx_step;
        logic [3:0] cnt;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_extra;
        logic out_en;
    } t_sts;

    localparam logic [0:255][7:0] SBOX = {
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [0:255][7:0] INV_SBOX = {
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // Multiply by x in GF(2^8).
    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Round constant for round key number idx (1 to 10).
    function automatic logic [7:0] rcon(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Next round key from the previous one. Byte 0 sits in bits 127:120.
    function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] t;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        t  = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // SubBytes followed by ShiftRows.
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        int src;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int row = 0; row < 4; row++) begin
                src = row + 4 * ((c + row) & 3);
                t[127 - 8 * (row + 4 * c) -: 8] = SBOX[s[127 - 8 * src -: 8]];
            end
        end
        return t;
    endfunction

    // Inverse ShiftRows followed by inverse SubBytes.
    function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
        logic [127:0] t;
        int dst;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int row = 0; row < 4; row++) begin
                dst = row + 4 * ((c + row) & 3);
                t[127 - 8 * dst -: 8] = INV_SBOX[s[127 - 8 * (row + 4 * c) -: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32 * c -: 8];
            a1 = s[119 - 32 * c -: 8];
            a2 = s[111 - 32 * c -: 8];
            a3 = s[103 - 32 * c -: 8];
            t[127 - 32 * c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            t[119 - 32 * c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            t[111 - 32 * c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            t[103 - 32 * c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        return t;
    endfunction

    // Products by 9, 11, 13 and 14, packed as {p9, p11, p13, p14}.
    function automatic logic [31:0] inv_mults(input logic [7:0] a);
        logic [7:0] x2, x4, x8;
        x2 = xtime(a);
        x4 = xtime(x2);
        x8 = xtime(x4);
        return {x8 ^ a, x8 ^ x2 ^ a, x8 ^ x4 ^ a, x8 ^ x4 ^ x2};
    endfunction

    function automatic logic [127:0] inv_mix_columns(input logic [127:0] s);
        logic [127:0] t;
        logic [31:0] m0, m1, m2, m3;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            m0 = inv_mults(s[127 - 32 * c -: 8]);
            m1 = inv_mults(s[119 - 32 * c -: 8]);
            m2 = inv_mults(s[111 - 32 * c -: 8]);
            m3 = inv_mults(s[103 - 32 * c -: 8]);
            // Field order in mN: [31:24] x9, [23:16] x11, [15:8] x13, [7:0] x14.
            t[127 - 32 * c -: 8] = m0[7:0] ^ m1[23:16] ^ m2[15:8] ^ m3[31:24];
            t[119 - 32 * c -: 8] = m0[31:24] ^ m1[7:0] ^ m2[23:16] ^ m3[15:8];
            t[111 - 32 * c -: 8] = m0[15:8] ^ m1[31:24] ^ m2[7:0] ^ m3[23:16];
            t[103 - 32 * c -: 8] = m0[23:16] ^ m1[15:8] ^ m2[31:24] ^ m3[7:0];
        end
        return t;
    endfunction

endpackage

>>> rtl/core/aes_bme_ctrl.sv
// Controller of the AES-128 block mode engine: sequences key expansion,
// rounds and result words. Depends on aes_bme_pkg.
module aes_bme_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_key_wr,
    input  logic              i_s_valid,
    input  logic              i_m_ready,
    input  aes_bme_pkg::t_sts i_sts,
    output aes_bme_pkg::t_cmd o_cmd,
    output logic              o_s_ready,
    output logic              o_m_valid
);
    import aes_bme_pkg::*;

    typedef enum logic [1:0] {
        S_KEXP,
        S_IDLE,
        S_RUN,
        S_EMIT
    } t_state;

    t_state     r_state;
    logic [3:0] r_cnt;
    logic       r_m_valid;

    // Commands decoded from the current state.
    always_comb begin
        o_cmd     = '0;
        o_cmd.cnt = r_cnt;
        case (r_state)
            S_KEXP: begin
                o_cmd.kx_load = (r_cnt == 4'd0);
                o_cmd.kx_step = (r_cnt != 4'd0);
            end
            S_IDLE: begin
                o_cmd.load_item = i_s_valid;
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
            end
            S_EMIT: begin
                o_cmd.emit     = !r_m_valid || i_m_ready;
                o_cmd.load_pad = (!r_m_valid || i_m_ready) && i_sts.need_extra;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // State, counter and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_KEXP;
            r_cnt     <= 4'd0;
            r_m_valid <= 1'b0;
        end else begin
            if (o_cmd.emit && i_sts.out_en) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_ready) begin
                r_m_valid <= 1'b0;
            end
            if (i_key_wr) begin
                r_state <= S_KEXP;
                r_cnt   <= 4'd0;
            end else begin
                case (r_state)
                    S_KEXP: begin
                        if (r_cnt == LAST_ROUND) begin
                            r_state <= S_IDLE;
                        end
                        r_cnt <= r_cnt + 4'd1;
                    end
                    S_IDLE: begin
                        if (o_cmd.load_item) begin
                            r_state <= S_RUN;
                            r_cnt   <= 4'd1;
                        end
                    end
                    S_RUN: begin
                        if (r_cnt == LAST_ROUND) begin
                            r_state <= S_EMIT;
                        end
                        r_cnt <= r_cnt + 4'd1;
                    end
                    S_EMIT: begin
                        if (o_cmd.emit) begin
                            r_state <= i_sts.need_extra ? S_RUN : S_IDLE;
                            r_cnt   <= 4'd1;
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_m_valid;

endmodule

>>> rtl/core/aes_bme_dp.sv
// Datapath of the AES-128 block mode engine: round key registers, one shared
// round unit, chain value, padding and unpadding. Depends on aes_bme_pkg.
module aes_bme_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  aes_bme_pkg::t_cmd i_cmd,
    input  logic [127:0]      i_data,
    input  logic [4:0]        i_byte_count,
    input  logic              i_final,
    input  logic [127:0]      i_key,
    input  logic [127:0]      i_iv,
    input  logic [2:0]        i_mode,
    output aes_bme_pkg::t_sts o_sts,
    output logic [127:0]      o_result,
    output logic [4:0]        o_valid_bytes,
    output logic              o_eom,
    output logic [1:0]        o_status
);
    import aes_bme_pkg::*;

    logic [127:0] r_rk [0:10];
    logic [127:0] r_kexp;
    logic [127:0] r_state;
    logic [127:0] r_chain;
    logic [127:0] r_ctext;
    logic         r_msg_start;
    logic         r_fin, r_extra, r_pad_blk, r_dec, r_cbc_enc, r_cbc_dec, r_mac;
    logic [127:0] r_res;
    logic [4:0]   r_vb;
    logic         r_eom;
    logic [1:0]   r_st;

    logic [2:0]   mode_eff;
    logic         in_dec, in_cbc_enc, in_cbc_dec, in_mac;
    logic [3:0]   kidx;
    logic [127:0] rk;
    logic [127:0] chain_eff;
    logic [127:0] padded;
    logic [127:0] enc_t, dec_t, nk;
    logic [127:0] result;
    logic [7:0]   pad_val;
    logic [1:0]   chk_st;
    logic [4:0]   chk_vb;

    // Decode of the mode register for the item being accepted.
    always_comb begin
        mode_eff   = (i_mode > MODE_CBC_MAC) ? MODE_ECB_ENC : i_mode;
        in_dec     = (mode_eff == MODE_ECB_DEC) || (mode_eff == MODE_CBC_DEC);
        in_cbc_enc = (mode_eff == MODE_CBC_ENC) || (mode_eff == MODE_CBC_MAC);
        in_cbc_dec = (mode_eff == MODE_CBC_DEC);
        in_mac     = (mode_eff == MODE_ECB_MAC) || (mode_eff == MODE_CBC_MAC);
    end

    // Round key select: first key on load, then the round's key.
    always_comb begin
        if (i_cmd.load_item) begin
            kidx = in_dec ? LAST_ROUND : 4'd0;
        end else if (i_cmd.load_pad) begin
            kidx = 4'd0;
        end else begin
            kidx = r_dec ? (LAST_ROUND - i_cmd.cnt) : i_cmd.cnt;
        end
        rk = r_rk[kidx];
    end

    // PKCS#7 padding of a short final block.
    always_comb begin
        chain_eff = r_msg_start ? i_iv : r_chain;
        padded    = i_data;
        if (i_final && (i_byte_count < BLOCK_BYTES)) begin
            for (int j = 0; j < 16; j++) begin
                if (5'(j) >= i_byte_count) begin
                    padded[127 - 8 * j -: 8] = {3'b000, BLOCK_BYTES - i_byte_count};
                end
            end
        end
    end

    // One round per cycle in either direction.
    always_comb begin
        enc_t = sub_shift(r_state);
        dec_t = inv_sub_shift(r_state) ^ rk;
        nk    = key_next(r_kexp, rcon(i_cmd.cnt));
    end

    // Finished block and pad check of a final decrypted block.
    always_comb begin
        result  = r_state ^ (r_cbc_dec ? r_chain : 128'd0);
        pad_val = result[7:0];
        chk_st  = ST_OK;
        chk_vb  = BLOCK_BYTES;
        if (pad_val == 8'd0 || pad_val > 8'd16) begin
            chk_st = ST_BAD_VALUE;
        end else begin
            for (int j = 0; j < 16; j++) begin
                if ((9'(j) + {1'b0, pad_val} >= 9'd16) &&
                    (result[127 - 8 * j -: 8] != pad_val)) begin
                    chk_st = ST_BAD_PAD;
                end
            end
            if (chk_st == ST_OK) begin
                chk_vb = BLOCK_BYTES - pad_val[4:0];
            end
        end
    end

    assign o_sts.need_extra = r_extra && !r_pad_blk;
    assign o_sts.out_en     = r_dec || !r_mac || (r_fin && !(r_extra && !r_pad_blk));

    // Round key registers, filled one round key a cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.kx_load) begin
            r_kexp   <= i_key;
            r_rk[0]  <= i_key;
        end else if (i_cmd.kx_step) begin
            r_kexp         <= nk;
            r_rk[i_cmd.cnt] <= nk;
        end
    end

    // Message start flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_start <= 1'b1;
        end else if (i_cmd.load_item) begin
            r_msg_start <= i_final;
        end
    end

    // Cipher state, chain value and item attributes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_ctext   <= i_data;
            r_chain   <= chain_eff;
            r_fin     <= i_final;
            r_extra   <= i_final && !in_dec && (i_byte_count >= BLOCK_BYTES);
            r_pad_blk <= 1'b0;
            r_dec     <= in_dec;
            r_cbc_enc <= in_cbc_enc;
            r_cbc_dec <= in_cbc_dec;
            r_mac     <= in_mac;
            if (in_dec) begin
                r_state <= i_data ^ rk;
            end else begin
                r_state <= padded ^ (in_cbc_enc ? chain_eff : 128'd0) ^ rk;
            end
        end else if (i_cmd.load_pad) begin
            r_pad_blk <= 1'b1;
            r_state   <= {16{8'h10}} ^ (r_cbc_enc ? r_state : 128'd0) ^ rk;
        end else if (i_cmd.step) begin
            if (r_dec) begin
                r_state <= (i_cmd.cnt == LAST_ROUND) ? dec_t : inv_mix_columns(dec_t);
            end else begin
                r_state <= ((i_cmd.cnt == LAST_ROUND) ? enc_t : mix_columns(enc_t)) ^ rk;
            end
        end
        if (i_cmd.emit) begin
            if (r_cbc_enc) begin
                r_chain <= r_state;
            end else if (r_cbc_dec) begin
                r_chain <= r_ctext;
            end
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit && o_sts.out_en) begin
            r_res <= result;
            r_eom <= r_fin && !o_sts.need_extra;
            if (r_dec && r_fin) begin
                r_vb <= chk_vb;
                r_st <= chk_st;
            end else begin
                r_vb <= BLOCK_BYTES;
                r_st <= ST_OK;
            end
        end
    end

    assign o_result      = r_res;
    assign o_valid_bytes = r_vb;
    assign o_eom         = r_eom;
    assign o_status      = r_st;

endmodule

>>> rtl/core/aes128_block_mode_engine.sv
// AES-128 block mode engine: each item runs in turn through load, ten rounds and result, and
// no new input word is taken until the item's result step is done; a full final block in encrypt
// or MAC modes also runs a pad block through the same round unit again.
// The single iterated round unit does one round per cycle.
// Synchronous active-low reset; after reset and after every key write the round keys
// are expanded, during which no input word is taken.
module aes128_block_mode_engine (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,  // data_high[63:0], data_low[127:64], byte_count[132:128]
    input  logic         s_tlast,  // final_block
    // Output stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,  // result_high[63:0], result_low[127:64], valid_bytes[132:128]
    output logic         m_tlast,  // end_of_message
    output logic [1:0]   m_tuser,  // status[1:0]
    // Configuration port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    import aes_bme_pkg::*;

    logic [63:0]  r_key_high, r_key_low, r_iv_high, r_iv_low;
    logic [2:0]   r_mode;
    logic         cfg_wr;
    logic [2:0]   cfg_idx;
    logic         key_wr;
    t_cmd         cmd;
    t_sts         sts;
    logic [127:0] result;
    logic [4:0]   valid_bytes;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[5:3];
    assign key_wr  = cfg_wr && ((cfg_idx == REG_KEY_HIGH) || (cfg_idx == REG_KEY_LOW));

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_iv_high  <= '0;
            r_iv_low   <= '0;
            r_mode     <= MODE_ECB_ENC;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_KEY_HIGH: r_key_high <= pwdata;
                REG_KEY_LOW:  r_key_low  <= pwdata;
                REG_IV_HIGH:  r_iv_high  <= pwdata;
                REG_IV_LOW:   r_iv_low   <= pwdata;
                REG_MODE:     r_mode     <= pwdata[2:0];
                default:      r_mode     <= r_mode;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (cfg_idx)
            REG_KEY_HIGH: prdata = r_key_high;
            REG_KEY_LOW:  prdata = r_key_low;
            REG_IV_HIGH:  prdata = r_iv_high;
            REG_IV_LOW:   prdata = r_iv_low;
            REG_MODE:     prdata = {61'd0, r_mode};
            default:      prdata = '0;
        endcase
    end

    aes_bme_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_key_wr  (key_wr),
        .i_s_valid (s_tvalid),
        .i_m_ready (m_tready),
        .i_sts     (sts),
        .o_cmd     (cmd),
        .o_s_ready (s_tready),
        .o_m_valid (m_tvalid)
    );

    aes_bme_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data        ({s_tdata[63:0], s_tdata[127:64]}),
        .i_byte_count  (s_tdata[132:128]),
        .i_final       (s_tlast),
        .i_key         ({r_key_high, r_key_low}),
        .i_iv          ({r_iv_high, r_iv_low}),
        .i_mode        (r_mode),
        .o_sts         (sts),
        .o_result      (result),
        .o_valid_bytes (valid_bytes),
        .o_eom         (m_tlast),
        .o_status      (m_tuser)
    );

    assign m_tdata = {3'b000, valid_bytes, result[63:0], result[127:64]};

endmodule

>>> rtl/core/aes_bme_chk.sv
// Port-level checker for the AES-128 block mode engine, bound to the top level.
// Depends only on the top level's ports.
module aes_bme_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata,
    input logic         m_tlast,
    input logic [1:0]   m_tuser
);

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // Reset empties the output and starts key expansion.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid && !s_tready)
        else $error("block not quiet after reset");

    // One item at a time in the round unit.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    // Error status only on the last word of a message.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser != 2'd0) |-> m_tlast)
        else $error("error status on a non-final word");

    // Valid byte count never exceeds a block.
    a_valid_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tdata[132:128] <= 5'd16)
        else $error("valid byte count above sixteen");

endmodule

bind aes128_block_mode_engine aes_bme_chk u_aes_bme_chk (.*);

>>> tb/aes128_block_mode_engine_chk.sv
// Checker for the AES-128 block mode engine: watches the input, output and register channels.
// Predicts every result word with its own AES-128 model and compares them in order.
// Depends on aes_bme_pkg for register indexes, mode and status codes and the block size.
`timescale 1ns / 1ps

module aes128_block_mode_engine_chk
    import aes_bme_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [135:0] s_tdata,  // data_high[63:0], data_low[127:64], byte_count[132:128]
    input  logic         s_tlast,  // final_block
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [135:0] m_tdata,  // result_high[63:0], result_low[127:64], valid_bytes[132:128]
    input  logic         m_tlast,  // end_of_message
    input  logic [1:0]   m_tuser,  // status[1:0]
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    input  logic         pready,
    output int           o_outstanding,
    output int           o_errors
);

    // Block with byte 0 in the top bits, as on the bus.
    typedef logic [0:15][7:0] aes_block_t;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
        logic [4:0]  nbytes;
        logic        eom;
        logic [1:0]  status;
    } result_word_t;

    logic [7:0]  fwd_sub [256];
    logic [7:0]  inv_sub [256];
    aes_block_t  round_keys [11];
    logic [127:0] key_reg;
    logic [127:0] iv_reg;
    logic [2:0]  mode_reg;
    logic [127:0] chain;
    logic        at_msg_start;
    result_word_t expected_words [$];

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] x;
        logic [7:0] r;
        x = {1'b0, a};
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r ^= x[7:0];
            x = x << 1;
            if (x[8]) x ^= 9'h11b;
        end
        return r;
    endfunction

    // Build the S-box from field inverses and the affine map.
    function automatic void build_sbox();
        logic [7:0] inv;
        logic [7:0] s;
        for (int v = 0; v < 256; v++) begin
            inv = 8'h00;
            for (int w = 1; w < 256; w++)
                if (gf_mul(v[7:0], w[7:0]) == 8'h01) inv = w[7:0];
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            fwd_sub[v] = s;
            inv_sub[s] = v[7:0];
        end
    endfunction

    function automatic void expand_keys();
        aes_block_t k;
        logic [7:0] t [4];
        logic [7:0] rc;
        rc = 8'h01;
        round_keys[0] = key_reg;
        for (int r = 1; r <= 10; r++) begin
            k = round_keys[r - 1];
            t[0] = fwd_sub[k[13]] ^ rc;
            t[1] = fwd_sub[k[14]];
            t[2] = fwd_sub[k[15]];
            t[3] = fwd_sub[k[12]];
            for (int i = 0; i < 16; i++)
                round_keys[r][i] = k[i] ^ (i < 4 ? t[i] : round_keys[r][i - 4]);
            rc = gf_mul(rc, 8'h02);
        end
    endfunction

    function automatic aes_block_t cipher(input aes_block_t s);
        aes_block_t t;
        logic [7:0] a0, a1, a2, a3;
        s ^= round_keys[0];
        for (int r = 1; r <= 10; r++) begin
            for (int c = 0; c < 4; c++)
                for (int row = 0; row < 4; row++)
                    t[row + 4 * c] = fwd_sub[s[row + 4 * ((c + row) % 4)]];
            if (r < 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
                    s[4 * c]     = gf_mul(a0, 2) ^ gf_mul(a1, 3) ^ a2 ^ a3;
                    s[4 * c + 1] = a0 ^ gf_mul(a1, 2) ^ gf_mul(a2, 3) ^ a3;
                    s[4 * c + 2] = a0 ^ a1 ^ gf_mul(a2, 2) ^ gf_mul(a3, 3);
                    s[4 * c + 3] = gf_mul(a0, 3) ^ a1 ^ a2 ^ gf_mul(a3, 2);
                end
            end else begin
                s = t;
            end
            s ^= round_keys[r];
        end
        return s;
    endfunction

    function automatic aes_block_t inv_cipher(input aes_block_t s);
        aes_block_t t;
        logic [7:0] a0, a1, a2, a3;
        s ^= round_keys[10];
        for (int r = 9; r >= 0; r--) begin
            for (int c = 0; c < 4; c++)
                for (int row = 0; row < 4; row++)
                    t[row + 4 * ((c + row) % 4)] = inv_sub[s[row + 4 * c]];
            s = t ^ round_keys[r];
            if (r > 0) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = s[4 * c]; a1 = s[4 * c + 1]; a2 = s[4 * c + 2]; a3 = s[4 * c + 3];
                    s[4 * c]     = gf_mul(a0, 14) ^ gf_mul(a1, 11)
                                   ^ gf_mul(a2, 13) ^ gf_mul(a3, 9);
                    s[4 * c + 1] = gf_mul(a0, 9) ^ gf_mul(a1, 14)
                                   ^ gf_mul(a2, 11) ^ gf_mul(a3, 13);
                    s[4 * c + 2] = gf_mul(a0, 13) ^ gf_mul(a1, 9)
                                   ^ gf_mul(a2, 14) ^ gf_mul(a3, 11);
                    s[4 * c + 3] = gf_mul(a0, 11) ^ gf_mul(a1, 13)
                                   ^ gf_mul(a2, 9) ^ gf_mul(a3, 14);
                end
            end
        end
        return s;
    endfunction

    function automatic void push_result(input aes_block_t b, input logic [4:0] n,
                                        input logic eom, input logic [1:0] st);
        result_word_t w;
        w.hi = b[0:7];
        w.lo = b[8:15];
        w.nbytes = n;
        w.eom = eom;
        w.status = st;
        expected_words = {expected_words, w};
    endfunction

    // Encrypt one block, through the chain value in CBC and CBC-MAC.
    function automatic aes_block_t encrypt_step(input aes_block_t b, input logic cbc);
        if (cbc) b ^= chain;
        b = cipher(b);
        if (cbc) chain = b;
        return b;
    endfunction

    // Work out the result words of one accepted input word.
    function automatic void predict_word(input logic [135:0] d, input logic fin);
        aes_block_t b;
        aes_block_t ct;
        logic [2:0] m;
        logic [4:0] n;
        logic [7:0] pad;
        logic [1:0] st;
        logic [4:0] nvalid;
        logic cbc, mac, extra;
        m = (mode_reg > MODE_CBC_MAC) ? MODE_ECB_ENC : mode_reg;
        n = d[132:128];
        b = {d[63:0], d[127:64]};
        if (at_msg_start) chain = iv_reg;
        at_msg_start = fin;
        if (m == MODE_ECB_DEC || m == MODE_CBC_DEC) begin
            ct = b;
            b = inv_cipher(b);
            if (m == MODE_CBC_DEC) begin
                b ^= chain;
                chain = ct;
            end
            if (!fin) begin
                push_result(b, BLOCK_BYTES, 1'b0, ST_OK);
                return;
            end
            pad = b[15];
            st = ST_OK;
            nvalid = BLOCK_BYTES;
            if (pad == 0 || pad > 16) begin
                st = ST_BAD_VALUE;
            end else begin
                for (int j = 16 - pad; j < 16; j++)
                    if (b[j] != pad) st = ST_BAD_PAD;
                if (st == ST_OK) nvalid = 5'(16 - pad);
            end
            push_result(b, nvalid, 1'b1, st);
            return;
        end
        cbc = (m == MODE_CBC_ENC || m == MODE_CBC_MAC);
        mac = (m == MODE_ECB_MAC || m == MODE_CBC_MAC);
        extra = 1'b0;
        if (fin) begin
            if (n >= 16) extra = 1'b1;
            else for (int j = n; j < 16; j++) b[j] = 8'(16 - n);
        end
        b = encrypt_step(b, cbc);
        if (!mac) push_result(b, BLOCK_BYTES, fin && !extra, ST_OK);
        if (extra) begin
            b = encrypt_step({16{8'h10}}, cbc);
            if (!mac) push_result(b, BLOCK_BYTES, 1'b1, ST_OK);
        end
        if (mac && fin) push_result(b, BLOCK_BYTES, 1'b1, ST_OK);
    endfunction

    initial begin
        build_sbox();
    end

    // Every event is handled at the rising edge with the values sampled there.
    always @(posedge i_clk) begin
        result_word_t w;
        if (!i_rst_n) begin
            key_reg = '0;
            iv_reg = '0;
            mode_reg = MODE_ECB_ENC;
            chain = '0;
            at_msg_start = 1'b1;
            expand_keys();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[5:3])
                    REG_KEY_HIGH: begin key_reg[127:64] = pwdata; expand_keys(); end
                    REG_KEY_LOW:  begin key_reg[63:0] = pwdata; expand_keys(); end
                    REG_IV_HIGH:  iv_reg[127:64] = pwdata;
                    REG_IV_LOW:   iv_reg[63:0] = pwdata;
                    REG_MODE:     mode_reg = pwdata[2:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_words.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected result word %h last=%b user=%0d",
                             $time, m_tdata, m_tlast, m_tuser);
                end else begin
                    w = expected_words.pop_front();
                    if (m_tdata[63:0] !== w.hi || m_tdata[127:64] !== w.lo
                            || m_tdata[132:128] !== w.nbytes || m_tlast !== w.eom
                            || m_tuser !== w.status) begin
                        o_errors++;
                        $display("%0t: expected %h_%h n=%0d last=%b st=%0d,",
                                 $time, w.hi, w.lo, w.nbytes, w.eom, w.status,
                                 " got %h_%h n=%0d last=%b st=%0d",
                                 m_tdata[63:0], m_tdata[127:64], m_tdata[132:128],
                                 m_tlast, m_tuser);
                    end
                end
            end
            if (s_tvalid && s_tready) predict_word(s_tdata, s_tlast);
        end
        o_outstanding = expected_words.size();
    end

endmodule

>>> tb/aes128_block_mode_engine_tb.sv
// Testbench top for the AES-128 block mode engine: clock, reset, stimulus and verdict.
// Depends on aes_bme_pkg, the engine RTL and aes128_block_mode_engine_chk.
`timescale 1ns / 1ps

module aes128_block_mode_engine_tb;
    import aes_bme_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEM_TARGET = 1750;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;  // data_high[63:0], data_low[127:64], byte_count[132:128]
    logic         s_tlast;  // final_block
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;  // result_high[63:0], result_low[127:64], valid_bytes[132:128]
    logic         m_tlast;  // end_of_message
    logic [1:0]   m_tuser;  // status[1:0]
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [5:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;

    int outstanding;
    int errors;
    int words_sent;
    int send_idle_pct;
    int recv_stall_pct;
    logic hold_request;
    int hold_left;
    int quiet_cycles;
    logic capture_on;
    logic [136:0] captured [$];

    aes128_block_mode_engine uut (.*);

    aes128_block_mode_engine_chk checker_i (
        .i_clk, .i_rst_n, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_outstanding(outstanding), .o_errors(errors)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        m_tready = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request && hold_left == 0) hold_left = 400;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Keep encrypted words so they can be sent back through decryption.
    always @(posedge i_clk) begin
        if (capture_on && m_tvalid && m_tready) captured = {captured, {m_tlast, m_tdata}};
    end

    // Watchdog on cycles with no word moving on any channel.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("aes128_block_mode_engine_tb NOT OK");
            $finish;
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Offer one word; returns at the falling edge after it was taken.
    task automatic send_word(input logic [63:0] hi, input logic [63:0] lo,
                             input logic [4:0] nbytes, input logic fin);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, nbytes, lo, hi};
        s_tlast <= fin;
        do @(posedge i_clk); while (!s_tready);
        words_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand_word64();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [4:0] rand_count();
        return ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 16)) : 5'($urandom_range(17, 31));
    endfunction

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_word(rand_word64(), rand_word64(), rand_count(), i == len - 1);
    endtask

    // Wait until every expected result is in, then let the engine settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (outstanding != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic load_setting(input logic [127:0] key, input logic [127:0] iv,
                                input logic [2:0] mode);
        reg_write(REG_KEY_HIGH, key[127:64]);
        reg_write(REG_KEY_LOW, key[63:0]);
        reg_write(REG_IV_HIGH, iv[127:64]);
        reg_write(REG_IV_LOW, iv[63:0]);
        reg_write(REG_MODE, 64'(mode));
    endtask

    initial begin
        logic [127:0] key;
        logic [127:0] iv;
        logic [2:0] mode;
        logic [136:0] w;
        int phase;

        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 1'b0;
        capture_on = 1'b0;
        words_sent = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset key, a standard test vector and the undefined mode codes.
        send_word('0, '0, 5'd0, 1'b1);
        wait_idle();
        load_setting(128'h000102030405060708090a0b0c0d0e0f, '1, MODE_ECB_ENC);
        send_word(64'h0011223344556677, 64'h8899aabbccddeeff, 5'd16, 1'b1);
        send_word('1, '1, 5'd31, 1'b1);
        wait_idle();
        reg_write(REG_MODE, 64'd6);
        send_word('1, '0, 5'd15, 1'b1);
        wait_idle();
        reg_write(REG_MODE, 64'd7);
        send_word('0, '1, 5'd1, 1'b1);
        wait_idle();

        // Random phases; every ECB or CBC encrypt phase is sent back through decryption.
        phase = 0;
        while (words_sent < ITEM_TARGET) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            key = (phase == 1) ? '1 : (phase == 2) ? '0 : {rand_word64(), rand_word64()};
            iv = {rand_word64(), rand_word64()};
            mode = (phase < 8) ? 3'(phase % 8) : 3'($urandom_range(0, 7));
            load_setting(key, iv, mode);
            if (phase == 4) begin
                @(posedge i_clk);
                hold_request <= 1'b1;
                @(negedge i_clk);
                @(negedge i_clk);
                hold_request <= 1'b0;
            end
            captured.delete();
            capture_on = (mode == MODE_ECB_ENC || mode == MODE_CBC_ENC || mode > MODE_CBC_MAC);
            for (int k = 0; k < 8; k++) send_message($urandom_range(1, 5));
            wait_idle();
            capture_on = 1'b0;
            if (captured.size() != 0) begin
                reg_write(REG_MODE,
                          64'((mode == MODE_CBC_ENC) ? MODE_CBC_DEC : MODE_ECB_DEC));
                while (captured.size() != 0) begin
                    w = captured.pop_front();
                    // Now and then flip a bit so the padding check sees damage.
                    if ($urandom_range(0, 9) == 0) w[$urandom_range(0, 127)] ^= 1'b1;
                    send_word(w[63:0], w[127:64], rand_count(), w[136]);
                end
                wait_idle();
            end
            phase++;
        end

        wait_idle();
        if (errors == 0) begin
            $display("aes128_block_mode_engine_tb OK");
        end else begin
            $display("aes128_block_mode_engine_tb NOT OK");
        end
        $finish;
    end

endmodule
